// ===== src/srrip_pkg.sv =====
// Shared types and constants for the SRRIP replacement block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package srrip_pkg;

  localparam int unsigned WAYS    = 16;
  localparam int unsigned SETS    = 64;
  localparam int unsigned WayW    = $clog2(WAYS);
  localparam int unsigned SetW    = $clog2(SETS);
  localparam int unsigned RrpvW   = 2;
  localparam int unsigned RowW    = WAYS * RrpvW;

  localparam logic [RrpvW-1:0] RrpvMax    = 2'd3;
  localparam logic [RrpvW-1:0] RrpvInsert = 2'd2;
  localparam logic [RrpvW-1:0] RrpvHit    = 2'd0;

  // mode field codes
  typedef enum logic [1:0] {
    MODE_HIT  = 2'd0,
    MODE_FILL = 2'd1,
    MODE_MISS = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take input word, start row read
    logic commit;   // write row back, load result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_stall;  // result register full and not being drained
  } dp_stat_t;

endpackage : srrip_pkg

`default_nettype wire

// ===== src/srrip_ctrl.sv =====
// Controller FSM for the SRRIP replacement block.
// Depends on srrip_pkg; drives srrip_dpath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module srrip_ctrl
  import srrip_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!stat_i.out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.commit = !stat_i.out_stall;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule : srrip_ctrl

`default_nettype wire

// ===== src/srrip_dpath.sv =====
// Datapath: RRPV row memory, row valid bits, victim search and result register.
// Depends on srrip_pkg; sequenced by srrip_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module srrip_dpath
  import srrip_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_cmd_t        cmd_i,
  output dp_stat_t              stat_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [SetW-1:0]  set_index_i,
  input  wire logic [WayW-1:0]  way_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WayW-1:0]       chosen_way_o,
  output logic [1:0]            aging_rounds_o
);

  logic [RowW-1:0] mem_q [SETS];
  logic [SETS-1:0] row_valid_q;

  logic [RowW-1:0]  rd_row_q;
  logic             rd_valid_q;
  mode_e            mode_q;
  logic [SetW-1:0]  set_q;
  logic [WayW-1:0]  way_q;

  logic             out_valid_q;
  logic [WayW-1:0]  chosen_q;
  logic [1:0]       rounds_q;

  logic [RowW-1:0]  row;
  logic [RrpvW-1:0] lane  [WAYS];
  logic [RrpvW-1:0] aged  [WAYS];
  logic             any3, any2, any1;
  logic [RrpvW-1:0] top;
  logic [RrpvW-1:0] age;
  logic [WayW-1:0]  victim;
  logic [RowW-1:0]  row_wr;
  logic             wr_en;
  logic [WayW-1:0]  chosen_d;
  logic [1:0]       rounds_d;

  // row read, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_row_q <= mem_q[set_index_i];
      mode_q   <= mode_e'(mode_i);
      set_q    <= set_index_i;
      way_q    <= way_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_en) begin
      mem_q[set_q] <= row_wr;
    end
  end

  // never-written rows read as all ways at max
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) rd_valid_q <= row_valid_q[set_index_i];
      if (cmd_i.commit && wr_en) row_valid_q[set_q] <= 1'b1;
    end
  end

  assign row = rd_valid_q ? rd_row_q : {WAYS{RrpvMax}};

  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      lane[w] = row[w*RrpvW +: RrpvW];
      any3 = any3 | (lane[w] == 2'd3);
      any2 = any2 | (lane[w] == 2'd2);
      any1 = any1 | (lane[w] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    age = RrpvMax - top;
    for (int w = 0; w < WAYS; w++) begin
      aged[w] = lane[w] + age;
    end
    victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (aged[w] == RrpvMax) victim = WayW'(w);
    end
  end

  always_comb begin
    row_wr   = row;
    wr_en    = 1'b0;
    chosen_d = '0;
    rounds_d = '0;
    case (mode_q)
      MODE_HIT: begin
        wr_en    = 1'b1;
        chosen_d = way_q;
        row_wr[way_q*RrpvW +: RrpvW] = RrpvHit;
      end
      MODE_FILL: begin
        wr_en    = 1'b1;
        chosen_d = way_q;
        row_wr[way_q*RrpvW +: RrpvW] = RrpvInsert;
      end
      MODE_MISS: begin
        wr_en    = 1'b1;
        chosen_d = victim;
        rounds_d = age;
        for (int w = 0; w < WAYS; w++) begin
          row_wr[w*RrpvW +: RrpvW] = aged[w];
        end
        row_wr[victim*RrpvW +: RrpvW] = RrpvInsert;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      chosen_q <= chosen_d;
      rounds_q <= rounds_d;
    end
  end

  assign stat_o.out_stall = out_valid_q & ~out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign chosen_way_o     = chosen_q;
  assign aging_rounds_o   = rounds_q;

endmodule : srrip_dpath

`default_nettype wire

// ===== src/srrip_replacement_core.sv =====
// Top level of the SRRIP replacement block: controller plus datapath.
// Depends on srrip_pkg, srrip_ctrl and srrip_dpath.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one event word:
//   mode_i (hit, fill of a given way, miss with victim search, or no-op),
//   set_index_i and way_i. Output channel (out_valid_o / out_ready_i)
//   returns one word per event: chosen_way_o and aging_rounds_o.
//   The input word and its set row are registered on capture; the result
//   register is loaded on the commit that writes the updated row back.
//   No new event is taken until the read-modify-write of its set row
//   is done: read on capture in the idle state, then update and write
//   on commit in the update state.
//   A new event is taken while the previous result still sits in the
//   output register; if that register is still full when the next update
//   is due, the update waits and no further event is taken.
//   Reset clears the controller, the output valid and the per-row valid
//   bits; an unwritten row reads as every way at the maximum value, so no
//   clearing pass is needed and the block is usable straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module srrip_replacement_core
  import srrip_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [SetW-1:0]  set_index_i,
  input  wire logic [WayW-1:0]  way_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WayW-1:0]       chosen_way_o,
  output logic [1:0]            aging_rounds_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: idle/capture, then update/commit
  srrip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // row storage, victim search, result register
  srrip_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mode_i         (mode_i),
    .set_index_i    (set_index_i),
    .way_i          (way_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chosen_way_o   (chosen_way_o),
    .aging_rounds_o (aging_rounds_o)
  );

endmodule : srrip_replacement_core

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for srrip_replacement_core: queue-fed driver, monitor, watchdog.
// Keeps its own copy of the per-set re-reference values to predict every result word.
// Depends on srrip_pkg and the RTL of srrip_replacement_core.
`timescale 1ns / 1ps

module testbench;
  import srrip_pkg::*;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold  = 120;
  localparam int unsigned ItemsWanted = 1150;

  typedef struct packed {
    mode_e           mode;
    logic [SetW-1:0] set_idx;
    logic [WayW-1:0] way;
    logic            drain;  // sender waits for every result before offering this word
  } event_word_t;

  typedef struct packed {
    logic [WayW-1:0] way;
    logic [1:0]      rounds;
  } result_word_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [1:0]      mode_drv = '0;
  logic [SetW-1:0] set_drv = '0;
  logic [WayW-1:0] way_drv = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [WayW-1:0] chosen_way;
  logic [1:0]      aging_rounds;

  srrip_replacement_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode_drv),
    .set_index_i    (set_drv),
    .way_i          (way_drv),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .chosen_way_o   (chosen_way),
    .aging_rounds_o (aging_rounds)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted state: one 2-bit re-reference value per way of every set.
  logic [RrpvW-1:0] rrpv_q [SETS][WAYS];

  event_word_t  pending_q[$];
  result_word_t expected_q[$];
  event_word_t  cur_word;

  int unsigned words_in     = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt     = 0;
  int unsigned gap_cnt      = 0;
  int unsigned hold_cnt     = 0;
  int unsigned idle_cycles  = 0;
  bit          long_hold_done = 1'b0;

  // A middle stretch of the run goes without idling on either side.
  function automatic bit calm_phase();
    return words_in >= 500 && words_in < 650;
  endfunction

  // Mostly short gaps, the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase() || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Applies one event word to the predicted state and returns its result word.
  function automatic result_word_t srrip_apply(event_word_t ev);
    result_word_t     res;
    logic [RrpvW-1:0] top;
    logic [RrpvW-1:0] age;
    bit               found;
    res   = '0;
    top   = '0;
    found = 1'b0;
    case (ev.mode)
      MODE_HIT: begin
        res.way = ev.way;
        rrpv_q[ev.set_idx][ev.way] = RrpvHit;
      end
      MODE_FILL: begin
        res.way = ev.way;
        rrpv_q[ev.set_idx][ev.way] = RrpvInsert;
      end
      MODE_MISS: begin
        // age the whole set just far enough for its oldest way to reach the maximum
        for (int w = 0; w < WAYS; w++)
          if (rrpv_q[ev.set_idx][w] > top) top = rrpv_q[ev.set_idx][w];
        age = RrpvMax - top;
        for (int w = 0; w < WAYS; w++)
          rrpv_q[ev.set_idx][w] = rrpv_q[ev.set_idx][w] + age;
        for (int w = 0; w < WAYS; w++) begin
          if (!found && rrpv_q[ev.set_idx][w] == RrpvMax) begin
            res.way = w[WayW-1:0];
            found   = 1'b1;
          end
        end
        rrpv_q[ev.set_idx][res.way] = RrpvInsert;
        res.rounds = age;
      end
      default: ;  // no-op word: nothing changes, result is all zero
    endcase
    return res;
  endfunction

  function automatic void add_word(mode_e m, int unsigned s, int unsigned w, bit drain);
    event_word_t ev;
    ev.mode    = m;
    ev.set_idx = s[SetW-1:0];
    ev.way     = w[WayW-1:0];
    ev.drain   = drain;
    pending_q.push_back(ev);
  endfunction

  // Driver: a word stays on the bus until taken, then a gap may follow.
  always @(posedge clk_i) begin
    logic taken;
    if (rst_ni) begin
      taken = in_valid && in_ready;
      if (taken) begin
        expected_q.push_back(srrip_apply(cur_word));
        words_in++;
      end
      if (in_valid && !taken) begin
        // hold the word until it is taken
      end else if (gap_cnt != 0) begin
        gap_cnt  <= gap_cnt - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain && expected_q.size() != 0)) begin
        cur_word = pending_q.pop_front();
        mode_drv <= cur_word.mode;
        set_drv  <= cur_word.set_idx;
        way_drv  <= cur_word.way;
        in_valid <= 1'b1;
        gap_cnt  <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, result_word_t want, result_word_t got);
    if (fail_cnt < 10)
      $display("%0t: %s: expected way %0d rounds %0d, got way %0d rounds %0d",
               $realtime, what, want.way, want.rounds, got.way, got.rounds);
    fail_cnt++;
  endtask

  // Monitor: checks every result word taken, and drives ready with stalls.
  always @(posedge clk_i) begin
    result_word_t got;
    result_word_t want;
    int unsigned  g;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        got.way    = chosen_way;
        got.rounds = aging_rounds;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (want.way != got.way || want.rounds != got.rounds)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        // one long hold-off so the block fills up and back-pressures its input
        long_hold_done <= 1'b1;
        hold_cnt       <= LongHold;
        out_ready      <= 1'b0;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (g != 0) begin
          hold_cnt  <= g - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned hot [3];
    int unsigned r;
    int unsigned s;
    int unsigned f;
    int unsigned len;

    for (int i = 0; i < SETS; i++)
      for (int w = 0; w < WAYS; w++)
        rrpv_q[i][w] = RrpvMax;

    // Directed: fresh set miss, fill and hit at the way extremes, no-op,
    // then a set with every way hit so the miss must age three times.
    add_word(MODE_MISS, 0, 9, 1'b0);
    add_word(MODE_FILL, 0, WAYS - 1, 1'b0);
    add_word(MODE_HIT, 0, 0, 1'b0);
    add_word(MODE_NOP, SETS - 1, WAYS - 1, 1'b0);
    add_word(MODE_FILL, 21, 10, 1'b0);
    add_word(MODE_MISS, 42, 5, 1'b0);
    for (int w = 0; w < WAYS; w++)
      add_word(MODE_HIT, SETS - 1, w, 1'b0);
    add_word(MODE_MISS, SETS - 1, 0, 1'b0);

    // Random bursts over a few hot sets, with sweeps that drive aging of
    // every depth, plus some noise across all sets and modes.
    while (pending_q.size() < ItemsWanted) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, SETS - 1);
      if (r < 20) begin
        // hit nearly every way, then a single miss or a fill, miss, hit, miss chain (three rounds, or one then two)
        for (int w = 0; w < WAYS; w++)
          add_word(MODE_HIT, s, (w + $urandom_range(0, 1)) % WAYS, 1'b0);
        f = $urandom_range(0, WAYS - 1);
        if ($urandom_range(0, 1)) begin
          add_word(MODE_MISS, s, $urandom_range(0, WAYS - 1), 1'b0);
        end else begin
          add_word(MODE_FILL, s, f, 1'b0);
          add_word(MODE_MISS, s, $urandom_range(0, WAYS - 1), 1'b0);
          add_word(MODE_HIT, s, f, 1'b0);
          add_word(MODE_MISS, s, $urandom_range(0, WAYS - 1), 1'b0);
        end
      end else begin
        for (int i = 0; i < 3; i++) hot[i] = $urandom_range(0, SETS - 1);
        len = $urandom_range(20, 60);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          s = hot[$urandom_range(0, 2)];
          if (r < 8)
            add_word(mode_e'($urandom_range(0, 3)), $urandom_range(0, SETS - 1),
                     $urandom_range(0, WAYS - 1), $urandom_range(0, 149) == 0);
          else if (r < 55)
            add_word(MODE_HIT, s, $urandom_range(0, WAYS - 1), 1'b0);
          else if (r < 70)
            add_word(MODE_FILL, s, $urandom_range(0, WAYS - 1), 1'b0);
          else
            add_word(MODE_MISS, s, $urandom_range(0, WAYS - 1),
                     $urandom_range(0, 99) == 0);
        end
      end
    end
    // the sender holds off until the directed words have all come back
    pending_q[WAYS + 7].drain = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      $display("%0d result words never arrived", expected_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
